### sv/zrse_pkg.sv
// Package for the zero-run sparse encoder: register indexes, width codes,
// result packing widths and the result record type. No dependencies.
`default_nettype none

package zrse_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_WIDTH    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_WIDTH = 1'd1;
    localparam int CFG_DATA_W = 2;

    // Element width codes
    localparam logic [1:0] VW_1BYTE = 2'd0;
    localparam logic [1:0] VW_2BYTE = 2'd1;
    localparam logic [1:0] VW_4BYTE = 2'd2;
    localparam logic [1:0] VW_8BYTE = 2'd3;

    // Distance width codes (also used for the needed-width report)
    localparam logic [1:0] DW_8BIT  = 2'd0;
    localparam logic [1:0] DW_16BIT = 2'd1;
    localparam logic [1:0] DW_32BIT = 2'd2;

    localparam int ELEM_W  = 64;
    localparam int DIST_W  = 32;
    localparam int RCNT_W  = 32;
    localparam int RES_W   = DIST_W + ELEM_W + 2 * RCNT_W + 2;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ELEM_W-1:0] value;
        logic              has_value;
        logic              end_of_stream;
        logic [RCNT_W-1:0] value_count;
        logic [RCNT_W-1:0] distance_count;
        logic [1:0]        needed_width_code;
    } result_t;

endpackage

`default_nettype wire

### sv/zero_run_sparse_encoder.sv
// Zero-run sparse encoder top level: run counter, stream statistics and a
// two-entry output stage (result register plus skid register). Uses zrse_pkg.
`default_nettype none

// Usage
//   Input stream s_*: one element per word; s_tdata holds the element (only
//   the configured low bytes count), s_tlast marks the final element.
//   Result stream m_*: zero or one word per element. m_tdata fields, low bit
//   up: distance[31:0], value[95:32], value_count[127:96],
//   distance_count[159:128], needed_width_code[161:160], zero pad. m_tuser is
//   has_value, m_tlast is end_of_stream.
//   Config port: cfg_wr_en/cfg_index/cfg_wdata, index 0 = element width code,
//   index 1 = distance width code. Write only while the stream is idle.
//   Each result is registered (result register, or skid register on a stall) before it is on m_*.
//   Throughput: one element per cycle while s_tready is high; the run counter and
//   the statistics are computed combinationally from the registered state.
//   Stall: the skid register absorbs one result while m_tready is low, then
//   s_tready drops until the skid register drains into the result register.
//   Reset (aresetn low, synchronous): both config codes return to 0, the run
//   and statistics clear and both output entries empty. No clearing pass.
//   After a last element all stream state clears for the next stream.

module zero_run_sparse_encoder
    import zrse_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [ELEM_W-1:0]      s_tdata,   // element[63:0]
    input  wire logic                   s_tlast,   // is_last

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // distance, value, value_count,
                                                   // distance_count, needed_width_code
    output logic                        m_tuser,   // has_value
    output logic                        m_tlast    // end_of_stream
);

    // ---------------- configuration ----------------
    logic [1:0] value_width_reg;
    logic [1:0] distance_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_width_reg    <= VW_1BYTE;
            distance_width_reg <= DW_8BIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_VALUE_WIDTH:    value_width_reg    <= cfg_wdata;
                CFG_DISTANCE_WIDTH: distance_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stream state ----------------
    logic [DIST_W-1:0]     zero_run_reg,       zero_run_next;
    logic [DIST_W-1:0]     longest_run_reg,    longest_run_next;
    logic [COUNT_BITS-1:0] values_seen_reg,    values_seen_next;
    logic [COUNT_BITS-1:0] distances_seen_reg, distances_seen_next;

    logic              s_fire;
    logic [ELEM_W-1:0] elem_mask;
    logic [ELEM_W-1:0] elem;
    logic              elem_nz;
    logic              run_full;
    logic [DIST_W-1:0] run_inc;
    logic              emit;
    logic              takes_value;
    logic [DIST_W-1:0] dist_raw;
    logic [DIST_W-1:0] dist_mask;
    logic [DIST_W-1:0] longest_upd;
    logic [COUNT_BITS-1:0] values_upd;
    logic [COUNT_BITS-1:0] distances_upd;
    logic [63:0]       values_ext;
    logic [63:0]       distances_ext;
    logic [1:0]        needed_code;
    result_t           res_new;

    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        case (value_width_reg)
            VW_1BYTE: elem_mask = ELEM_W'(64'h0000_0000_0000_00FF);
            VW_2BYTE: elem_mask = ELEM_W'(64'h0000_0000_0000_FFFF);
            VW_4BYTE: elem_mask = ELEM_W'(64'h0000_0000_FFFF_FFFF);
            default:  elem_mask = '1;
        endcase
        case (distance_width_reg)
            DW_8BIT:  dist_mask = DIST_W'(32'h0000_00FF);
            DW_16BIT: dist_mask = DIST_W'(32'h0000_FFFF);
            default:  dist_mask = '1;   // reserved code acts as 32 bits
        endcase
    end

    assign elem        = s_tdata & elem_mask;
    assign elem_nz     = |elem;
    assign run_full    = &zero_run_reg;
    assign run_inc     = zero_run_reg + 1'b1;
    // nonzero element or a split of a full run both carry a value
    assign takes_value = elem_nz || run_full;
    assign emit        = takes_value || s_tlast;
    assign dist_raw    = elem_nz ? zero_run_reg : (run_full ? '1 : run_inc);

    assign longest_upd   = (emit && dist_raw > longest_run_reg) ? dist_raw : longest_run_reg;
    assign values_upd    = (takes_value && !(&values_seen_reg))
                         ? values_seen_reg + 1'b1 : values_seen_reg;
    assign distances_upd = (emit && !(&distances_seen_reg))
                         ? distances_seen_reg + 1'b1 : distances_seen_reg;

    // reported counts clamp at 32 bits
    assign values_ext    = 64'(values_upd);
    assign distances_ext = 64'(distances_upd);

    always_comb begin
        if (|longest_upd[DIST_W-1:16]) begin
            needed_code = DW_32BIT;
        end else if (|longest_upd[15:8]) begin
            needed_code = DW_16BIT;
        end else begin
            needed_code = DW_8BIT;
        end
    end

    always_comb begin
        res_new.distance      = dist_raw & dist_mask;
        res_new.value         = elem;   // zero for split and trailing entries
        res_new.has_value     = takes_value;
        res_new.end_of_stream = s_tlast;
        if (s_tlast) begin
            res_new.value_count       = (|values_ext[63:32]) ? '1 : values_ext[31:0];
            res_new.distance_count    = (|distances_ext[63:32]) ? '1 : distances_ext[31:0];
            res_new.needed_width_code = needed_code;
        end else begin
            res_new.value_count       = '0;
            res_new.distance_count    = '0;
            res_new.needed_width_code = DW_8BIT;
        end
    end

    always_comb begin
        zero_run_next       = zero_run_reg;
        longest_run_next    = longest_run_reg;
        values_seen_next    = values_seen_reg;
        distances_seen_next = distances_seen_reg;
        if (s_fire) begin
            if (s_tlast) begin
                zero_run_next       = '0;
                longest_run_next    = '0;
                values_seen_next    = '0;
                distances_seen_next = '0;
            end else begin
                zero_run_next       = emit ? '0 : run_inc;
                longest_run_next    = longest_upd;
                values_seen_next    = values_upd;
                distances_seen_next = distances_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg       <= '0;
            longest_run_reg    <= '0;
            values_seen_reg    <= '0;
            distances_seen_reg <= '0;
        end else begin
            zero_run_reg       <= zero_run_next;
            longest_run_reg    <= longest_run_next;
            values_seen_reg    <= values_seen_next;
            distances_seen_reg <= distances_seen_next;
        end
    end

    // ---------------- output register + skid ----------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    res_push;

    assign res_push = s_fire && emit;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // input is held off; drain skid into the result register
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_push) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (res_push) begin
            if (!out_valid_reg || m_tready) begin
                out_reg <= res_new;
            end else begin
                skid_reg <= res_new;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_reg.needed_width_code, out_reg.distance_count,
                                 out_reg.value_count, out_reg.value, out_reg.distance});
    assign m_tuser  = out_reg.has_value;
    assign m_tlast  = out_reg.end_of_stream;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> m_tvalid)
        else $error("emitted result not presented");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (zero_run_reg == '0 && longest_run_reg == '0
                                 && values_seen_reg == '0 && distances_seen_reg == '0))
        else $error("stream state not cleared after last element");

    a_needed_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.needed_width_code == DW_8BIT
                      || out_reg.needed_width_code == DW_16BIT
                      || out_reg.needed_width_code == DW_32BIT))
        else $error("needed width code out of range");

endmodule

`default_nettype wire
